// ===== design/lpw_pkg.sv =====
// ----------------------------------------------------------------------------
// lpw_pkg : shared types and constants for the LED pixel wire word packer
// Command format between front and back, sizes and the pulse expansion.
// ----------------------------------------------------------------------------
package lpw_pkg;

  localparam int unsigned MAX_FRAME_PIXELS = 4096;
  localparam int unsigned LimitW           = 13;
  localparam logic [LimitW-1:0] LimitReset = 13'd4096;

  localparam int unsigned WordW    = 32;
  localparam int unsigned PixBitsW = 72;                 // 24 colour bits x 3
  localparam int unsigned BufW     = WordW + PixBitsW;   // leftover + one pixel
  localparam int unsigned CntW     = $clog2(BufW + 1);

  localparam int unsigned QueueDepth = 4;
  localparam int unsigned QPtrW      = $clog2(QueueDepth);
  localparam int unsigned QCntW      = $clog2(QueueDepth + 1);

  // APB register map
  localparam int unsigned PaddrW           = 3;
  localparam logic [0:0]  RegIdxPixelLimit = 1'b0;

  typedef struct packed {
    logic        encode;     // pixel passed the limit check
    logic [23:0] grb;
    logic        frame_end;
  } lpw_cmd_t;

  // Each colour bit b becomes 1, b, 0 on the wire, MSB first.
  function automatic logic [PixBitsW-1:0] pulse_expand(input logic [23:0] grb);
    logic [PixBitsW-1:0] w;
    w = '0;
    for (int j = 0; j < 24; j++) begin
      w[3*j+2] = 1'b1;
      w[3*j+1] = grb[j];
      w[3*j]   = 1'b0;
    end
    return w;
  endfunction

endpackage

// ===== design/lpw_pix_if.sv =====
// ----------------------------------------------------------------------------
// lpw_pix_if : pixel input channel
// Valid/ready channel carrying one pixel and/or a frame-end marker per item.
// ----------------------------------------------------------------------------
interface lpw_pix_if;
  logic       valid;
  logic       ready;
  logic       has_pixel;
  logic [7:0] red;
  logic [7:0] green;
  logic [7:0] blue;
  logic       frame_end;

  modport source (output valid, has_pixel, red, green, blue, frame_end, input ready);
  modport sink   (input valid, has_pixel, red, green, blue, frame_end, output ready);
endinterface

// ===== design/lpw_word_if.sv =====
// ----------------------------------------------------------------------------
// lpw_word_if : wire word output channel
// Valid/ready channel carrying one 32-bit wire word per item.
// ----------------------------------------------------------------------------
interface lpw_word_if;
  logic        valid;
  logic        ready;
  logic [31:0] wire_word;
  logic        frame_last;

  modport source (output valid, wire_word, frame_last, input ready);
  modport sink   (input valid, wire_word, frame_last, output ready);
endinterface

// ===== design/lpw_front.sv =====
// ----------------------------------------------------------------------------
// lpw_front : input acceptance and pixel limit check
// Counts pixels per frame, drops those over the limit, hands commands to the queue.
// ----------------------------------------------------------------------------
module lpw_front (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  lpw_pix_if.sink                   pix,
  input  logic [lpw_pkg::LimitW-1:0] pixel_limit_i,
  output logic                      cmd_valid_o,
  input  logic                      cmd_ready_i,
  output lpw_pkg::lpw_cmd_t         cmd_o
);

  localparam logic [16:0] MaxPix = 17'(lpw_pkg::MAX_FRAME_PIXELS);

  logic [lpw_pkg::LimitW-1:0] pixels_q, pixels_d;
  logic [16:0]                limit_eff;
  logic                       accept;
  logic                       encode;

  assign limit_eff = ({4'b0, pixel_limit_i} > MaxPix) ? MaxPix : {4'b0, pixel_limit_i};
  assign encode    = pix.has_pixel && ({4'b0, pixels_q} < limit_eff);

  // items that produce no word are taken without touching the queue
  assign pix.ready   = cmd_ready_i;
  assign accept      = pix.valid && pix.ready;
  assign cmd_valid_o = pix.valid && (encode || pix.frame_end);

  assign cmd_o.encode    = encode;
  assign cmd_o.grb       = {pix.green, pix.red, pix.blue};
  assign cmd_o.frame_end = pix.frame_end;

  always_comb begin
    pixels_d = pixels_q;
    if (accept) begin
      if (pix.frame_end) begin
        pixels_d = '0;
      end else if (encode) begin
        pixels_d = pixels_q + 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pixels_q <= '0;
    end else begin
      pixels_q <= pixels_d;
    end
  end

endmodule

// ===== design/lpw_cmd_fifo.sv =====
// ----------------------------------------------------------------------------
// lpw_cmd_fifo : short command queue
// Decouples the front from the word packing back end.
// ----------------------------------------------------------------------------
module lpw_cmd_fifo (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              wr_valid_i,
  output logic              wr_ready_o,
  input  lpw_pkg::lpw_cmd_t wr_data_i,
  output logic              rd_valid_o,
  input  logic              rd_ready_i,
  output lpw_pkg::lpw_cmd_t rd_data_o
);

  lpw_pkg::lpw_cmd_t          mem_q [lpw_pkg::QueueDepth];
  logic [lpw_pkg::QPtrW-1:0]  wr_ptr_q, rd_ptr_q;
  logic [lpw_pkg::QCntW-1:0]  cnt_q, cnt_d;
  logic                       push, pop;

  assign wr_ready_o = (cnt_q != lpw_pkg::QCntW'(lpw_pkg::QueueDepth));
  assign rd_valid_o = (cnt_q != '0);
  assign rd_data_o  = mem_q[rd_ptr_q];
  assign push       = wr_valid_i && wr_ready_o;
  assign pop        = rd_valid_o && rd_ready_i;

  always_comb begin
    cnt_d = cnt_q;
    if (push && !pop) begin
      cnt_d = cnt_q + 1'b1;
    end else if (pop && !push) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      cnt_q <= cnt_d;
      if (push) begin
        wr_ptr_q <= wr_ptr_q + 1'b1;
      end
      if (pop) begin
        rd_ptr_q <= rd_ptr_q + 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wr_ptr_q] <= wr_data_i;
    end
  end

endmodule

// ===== design/lpw_back.sv =====
// ----------------------------------------------------------------------------
// lpw_back : wire bit packer
// Expands pixels to pulse bits, emits 32-bit words, pads and ends frames.
// ----------------------------------------------------------------------------
module lpw_back (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              cmd_valid_i,
  output logic              cmd_ready_o,
  input  lpw_pkg::lpw_cmd_t cmd_i,
  lpw_word_if.source        word
);

  localparam int unsigned BufW = lpw_pkg::BufW;
  localparam int unsigned CntW = lpw_pkg::CntW;

  // bits are held left aligned: earliest pending bit at the top, zeros below
  logic [BufW-1:0] buf_q, buf_d, buf_post;
  logic [CntW-1:0] cnt_q, cnt_d, cnt_post;
  logic            end_q, end_d, end_post;
  logic            out_valid_q, out_valid_d;
  logic [31:0]     out_word_q, out_word_d;
  logic            out_last_q, out_last_d;
  logic            out_free, emit_want, do_emit, full_word;
  logic [BufW-1:0] pix_bits;

  assign out_free  = !out_valid_q || word.ready;
  assign full_word = (cnt_q >= CntW'(32));
  assign emit_want = full_word || end_q;
  assign do_emit   = emit_want && out_free;

  always_comb begin
    buf_post    = buf_q;
    cnt_post    = cnt_q;
    end_post    = end_q;
    out_valid_d = out_valid_q && !word.ready;
    out_word_d  = out_word_q;
    out_last_d  = out_last_q;
    if (do_emit) begin
      out_valid_d = 1'b1;
      out_word_d  = buf_q[BufW-1 -: 32];
      out_last_d  = 1'b0;
      if (full_word) begin
        buf_post = buf_q << 32;
        cnt_post = cnt_q - CntW'(32);
      end else if (cnt_q != '0) begin
        // padded partial word, zeros already below
        buf_post = '0;
        cnt_post = '0;
      end else begin
        out_word_d = '0;
        out_last_d = 1'b1;
        buf_post   = '0;
        end_post   = 1'b0;
      end
    end
  end

  assign cmd_ready_o = (cnt_post < CntW'(32)) && !end_post;
  assign pix_bits    = {lpw_pkg::pulse_expand(cmd_i.grb), 32'b0} >> cnt_post[4:0];

  always_comb begin
    buf_d = buf_post;
    cnt_d = cnt_post;
    end_d = end_post;
    if (cmd_valid_i && cmd_ready_o) begin
      end_d = cmd_i.frame_end;
      if (cmd_i.encode) begin
        buf_d = buf_post | pix_bits;
        cnt_d = cnt_post + CntW'(lpw_pkg::PixBitsW);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      buf_q       <= '0;
      cnt_q       <= '0;
      end_q       <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      buf_q       <= buf_d;
      cnt_q       <= cnt_d;
      end_q       <= end_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_word_q <= out_word_d;
    out_last_q <= out_last_d;
  end

  assign word.valid      = out_valid_q;
  assign word.wire_word  = out_word_q;
  assign word.frame_last = out_last_q;

  a_cnt_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= CntW'(BufW))
    else $error("pending bit count out of range");

  a_last_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && out_last_q) |-> (out_word_q == '0))
    else $error("frame end word not zero");

  a_no_pop_in_flush: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (end_q && !do_emit) |-> !cmd_ready_o)
    else $error("command taken while frame flush pending");

  // a following frame end may be taken in the same cycle, so end_q can rise again
  a_zero_word_next: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (do_emit && end_q && (cnt_q == '0)) |=> (out_valid_q && out_last_q))
    else $error("frame end word not issued");

endmodule

// ===== design/led_pixel_wire_word_packer_top.sv =====
// ----------------------------------------------------------------------------
// led_pixel_wire_word_packer_top : LED strip pixel to wire word packer
// Encodes pixels into three-bit pulse code packed into 32-bit wire words.
// ----------------------------------------------------------------------------
// Usage:
//   pix_i  : one item per pixel (has_pixel, red, green, blue) and/or a
//            frame_end marker. Sent as G, R, B, MSB first, each bit as 1,b,0.
//   word_o : 32-bit wire words, earliest bit in bit 31. At frame end a
//            partial word is zero padded, then an all-zero word with
//            frame_last set closes the frame.
//   APB    : register 0 (byte 0) pixel_limit, reset 4096; pixels past
//            min(pixel_limit, 4096) in a frame are dropped.
// Throughput: the word output moves one word a cycle while word_o is not
//   stalled; a pixel is 72 bits, so two or three words, about 2.25 words per
//   pixel averaged, plus up to two words at frame end. Set by the single word output register.
// A four-entry command queue lets the input run ahead while word_o is
//   stalled; pix_i.ready drops only when that queue is full.
// Reset clears the leftover bits, the frame pixel count and the queue;
//   pixel_limit returns to 4096. No clearing pass is needed.
// ----------------------------------------------------------------------------
module led_pixel_wire_word_packer_top (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  lpw_pix_if.sink                    pix_i,
  lpw_word_if.source                 word_o,
  input  logic                       psel,
  input  logic                       penable,
  input  logic                       pwrite,
  input  logic [lpw_pkg::PaddrW-1:0] paddr,
  input  logic [31:0]                pwdata,
  output logic [31:0]                prdata,
  output logic                       pready
);

  logic [lpw_pkg::LimitW-1:0] limit_q;
  logic                       reg_sel;
  logic                       wr_en;

  logic              f_valid, f_ready;
  lpw_pkg::lpw_cmd_t f_cmd;
  logic              b_valid, b_ready;
  lpw_pkg::lpw_cmd_t b_cmd;

  assign pready  = 1'b1;
  assign reg_sel = (paddr[2] == lpw_pkg::RegIdxPixelLimit);
  assign wr_en   = psel && penable && pwrite && pready && reg_sel;
  assign prdata  = reg_sel ? {19'b0, limit_q} : 32'b0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      limit_q <= lpw_pkg::LimitReset;
    end else if (wr_en) begin
      limit_q <= pwdata[lpw_pkg::LimitW-1:0];
    end
  end

  lpw_front u_front (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .pix           (pix_i),
    .pixel_limit_i (limit_q),
    .cmd_valid_o   (f_valid),
    .cmd_ready_i   (f_ready),
    .cmd_o         (f_cmd)
  );

  lpw_cmd_fifo u_fifo (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .wr_valid_i (f_valid),
    .wr_ready_o (f_ready),
    .wr_data_i  (f_cmd),
    .rd_valid_o (b_valid),
    .rd_ready_i (b_ready),
    .rd_data_o  (b_cmd)
  );

  lpw_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_valid_i (b_valid),
    .cmd_ready_o (b_ready),
    .cmd_i       (b_cmd),
    .word        (word_o)
  );

endmodule

// ===== tb/tb_led_pixel_wire_word_packer_top.sv =====
// ----------------------------------------------------------------------------
// tb_led_pixel_wire_word_packer_top : self-checking bench for the wire packer
// Feeds pixel and frame-end items through a bursty valid/ready driver, stalls
// the word output on a changing pattern, and checks every word against an
// internal pulse-encoding predictor across several pixel_limit settings.
// ----------------------------------------------------------------------------
module tb_led_pixel_wire_word_packer_top;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned PaddrW = lpw_pkg::PaddrW;
  localparam int unsigned LimitW = lpw_pkg::LimitW;

  localparam logic [PaddrW-1:0] AddrPixelLimit = PaddrW'(4 * lpw_pkg::RegIdxPixelLimit);
  localparam logic [PaddrW-1:0] AddrUnmapped   = PaddrW'(4);
  localparam int unsigned       SettleCycles   = 16;
  localparam int unsigned       WatchdogLimit  = 2000;
  localparam int unsigned       RandPhases     = 7;
  localparam int unsigned       ItemsPerPhase  = 22;
  localparam logic [LimitW-1:0] PhaseLimits [RandPhases] =
    '{13'd8191, 13'd0, 13'd3, 13'd4096, 13'd1, 13'd5, 13'd0};

  typedef struct packed {
    logic       has_pixel;
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
    logic       frame_end;
  } pixel_item_t;

  typedef struct packed {
    logic [31:0] wire_word;
    logic        frame_last;
  } wire_word_t;

  logic clk_i  = 1'b0;
  logic rst_ni = 1'b0;

  // APB
  logic              psel    = 1'b0;
  logic              penable = 1'b0;
  logic              pwrite  = 1'b0;
  logic [PaddrW-1:0] paddr   = '0;
  logic [31:0]       pwdata  = '0;
  logic [31:0]       prdata;
  logic              pready;

  // pixel side drive
  logic       drv_valid     = 1'b0;
  logic       drv_has_pixel = 1'b0;
  logic [7:0] drv_red       = '0;
  logic [7:0] drv_green     = '0;
  logic [7:0] drv_blue      = '0;
  logic       drv_frame_end = 1'b0;
  logic       pix_taken     = 1'b0;
  logic       sink_ready    = 1'b0;

  lpw_pix_if  pix_if ();
  lpw_word_if word_if ();

  assign pix_if.valid     = drv_valid;
  assign pix_if.has_pixel = drv_has_pixel;
  assign pix_if.red       = drv_red;
  assign pix_if.green     = drv_green;
  assign pix_if.blue      = drv_blue;
  assign pix_if.frame_end = drv_frame_end;
  assign word_if.ready    = sink_ready;

  led_pixel_wire_word_packer_top uut (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .pix_i   (pix_if),
    .word_o  (word_if),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // predictor state
  logic [LimitW-1:0] limit_cfg    = lpw_pkg::LimitReset;
  logic [31:0]       lo_bits      = '0;
  int unsigned       lo_count     = 0;
  logic [LimitW-1:0] frame_pixels = '0;

  pixel_item_t pending_pixels [$];
  wire_word_t  expected_words [$];

  int unsigned error_count    = 0;
  int unsigned items_sent     = 0;
  int unsigned pixels_encoded = 0;
  int unsigned pixels_dropped = 0;
  int unsigned frames_closed  = 0;
  int unsigned words_checked  = 0;
  int unsigned limits_tried   = 0;
  int unsigned quiet_cycles   = 0;

  // ---------------------------------------------------------------- predictor
  function automatic void push_wire_bit(input logic b);
    lo_bits = {lo_bits[30:0], b};
    lo_count++;
    if (lo_count == 32) begin
      expected_words.push_back('{wire_word: lo_bits, frame_last: 1'b0});
      lo_bits  = '0;
      lo_count = 0;
    end
  endfunction

  function automatic void pack_pixel_item(input pixel_item_t it);
    logic [23:0] grb;
    int unsigned cap;
    cap = (limit_cfg > lpw_pkg::MAX_FRAME_PIXELS) ? lpw_pkg::MAX_FRAME_PIXELS : limit_cfg;
    grb = {it.green, it.red, it.blue};
    if (it.has_pixel) begin
      if (frame_pixels < cap) begin
        for (int j = 23; j >= 0; j--) begin
          push_wire_bit(1'b1);
          push_wire_bit(grb[j]);
          push_wire_bit(1'b0);
        end
        frame_pixels = frame_pixels + 1'b1;
        pixels_encoded++;
      end else begin
        pixels_dropped++;
      end
    end
    if (it.frame_end) begin
      // pad the partial word, then the closing zero word
      if (lo_count != 0)
        expected_words.push_back('{wire_word: lo_bits << (32 - lo_count), frame_last: 1'b0});
      expected_words.push_back('{wire_word: 32'h0, frame_last: 1'b1});
      lo_bits      = '0;
      lo_count     = 0;
      frame_pixels = '0;
      frames_closed++;
    end
  endfunction

  // --------------------------------------------------------------- scoreboard
  pixel_item_t seen_item;
  wire_word_t  head_word;

  always @(posedge clk_i) begin
    if (!rst_ni) begin
      pix_taken <= 1'b0;
    end else begin
      pix_taken <= pix_if.valid && pix_if.ready;
      if (pix_if.valid && pix_if.ready) begin
        seen_item.has_pixel = pix_if.has_pixel;
        seen_item.red       = pix_if.red;
        seen_item.green     = pix_if.green;
        seen_item.blue      = pix_if.blue;
        seen_item.frame_end = pix_if.frame_end;
        items_sent++;
        pack_pixel_item(seen_item);
      end
      if (word_if.valid && word_if.ready) begin
        if (expected_words.size() == 0) begin
          if (error_count < 10)
            $display("[%0t] unexpected word %h last %b", $realtime, word_if.wire_word,
                     word_if.frame_last);
          error_count++;
        end else begin
          head_word = expected_words.pop_front();
          words_checked++;
          if (head_word.wire_word !== word_if.wire_word ||
              head_word.frame_last !== word_if.frame_last) begin
            if (error_count < 10)
              $display("[%0t] word %0d: expected %h last %b, got %h last %b", $realtime,
                       words_checked, head_word.wire_word, head_word.frame_last,
                       word_if.wire_word, word_if.frame_last);
            error_count++;
          end
        end
      end
    end
  end

  // ------------------------------------------------------------------ driver
  pixel_item_t next_item;
  int unsigned burst_left = 1;
  int unsigned gap_left   = 0;

  always @(negedge clk_i) begin
    if (!rst_ni) begin
      drv_valid <= 1'b0;
    end else if (!drv_valid || pix_taken) begin
      if (gap_left > 0) begin
        gap_left--;
        drv_valid <= 1'b0;
      end else if (pending_pixels.size() > 0) begin
        next_item = pending_pixels.pop_front();
        drv_valid     <= 1'b1;
        drv_has_pixel <= next_item.has_pixel;
        drv_red       <= next_item.red;
        drv_green     <= next_item.green;
        drv_blue      <= next_item.blue;
        drv_frame_end <= next_item.frame_end;
        if (burst_left <= 1) begin
          burst_left = $urandom_range(1, 16);
          gap_left   = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
        end else begin
          burst_left--;
        end
      end else begin
        drv_valid <= 1'b0;
      end
    end
  end

  // --------------------------------------------------------- word side stalls
  int unsigned stall_mode = 0;
  int unsigned mode_left  = 0;
  int unsigned stall_left = 0;

  always @(negedge clk_i) begin
    if (mode_left == 0) begin
      stall_mode = $urandom_range(0, 2);
      mode_left  = $urandom_range(20, 80);
    end else begin
      mode_left--;
    end
    case (stall_mode)
      0: sink_ready <= 1'b1;
      1: sink_ready <= ($urandom_range(0, 3) != 0);
      default: begin
        if (stall_left > 0) begin
          stall_left--;
          sink_ready <= 1'b0;
        end else begin
          sink_ready <= 1'b1;
          if ($urandom_range(0, 3) == 0) stall_left = $urandom_range(1, 8);
        end
      end
    endcase
  end

  // ---------------------------------------------------------------- watchdog
  always @(posedge clk_i) begin
    if (!rst_ni || psel || (pix_if.valid && pix_if.ready) || (word_if.valid && word_if.ready))
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= WatchdogLimit) begin
      $display("FAILED: results differ");
      $finish;
    end
  end

  // ---------------------------------------------------------------- stimulus
  function automatic void add_item(input logic hp, input logic [7:0] r, input logic [7:0] g,
                                   input logic [7:0] b, input logic fe);
    pending_pixels.push_back('{has_pixel: hp, red: r, green: g, blue: b, frame_end: fe});
  endfunction

  function automatic logic [7:0] rand_byte();
    case ($urandom_range(0, 5))
      0: return 8'h00;
      1: return 8'hFF;
      default: return 8'($urandom);
    endcase
  endfunction

  // Mostly whole frames; some runs carry over into the next frame, some bare
  // frame ends and idle items mixed in.
  task automatic add_random_frames(input int unsigned n_items);
    int unsigned added;
    int unsigned len;
    int unsigned kind;
    added = 0;
    while (added < n_items) begin
      kind = $urandom_range(0, 9);
      len  = $urandom_range(1, 9);
      if (kind == 0) begin
        add_item(1'b0, rand_byte(), rand_byte(), rand_byte(), 1'b0);
      end else if (kind == 1) begin
        add_item(1'b0, rand_byte(), rand_byte(), rand_byte(), 1'b1);
        added++;
      end else if (kind == 2) begin
        for (int k = 0; k < len; k++) add_item(1'b1, rand_byte(), rand_byte(), rand_byte(), 1'b0);
        added += len;
      end else begin
        for (int k = 0; k < len - 1; k++)
          add_item(1'b1, rand_byte(), rand_byte(), rand_byte(), 1'b0);
        if ($urandom_range(0, 1) == 0) begin
          add_item(1'b1, rand_byte(), rand_byte(), rand_byte(), 1'b1);
        end else begin
          add_item(1'b1, rand_byte(), rand_byte(), rand_byte(), 1'b0);
          add_item(1'b0, rand_byte(), rand_byte(), rand_byte(), 1'b1);
          added++;
        end
        added += len;
      end
    end
  endtask

  // a dropped pixel makes no word, so give the pipeline time to empty
  task automatic wait_idle();
    do @(posedge clk_i);
    while (pending_pixels.size() != 0 || drv_valid || expected_words.size() != 0);
    repeat (SettleCycles) @(posedge clk_i);
  endtask

  task automatic apb_write(input logic [PaddrW-1:0] addr, input logic [31:0] data);
    @(negedge clk_i);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= addr;
    pwdata  <= data;
    @(negedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    while (!pready) @(posedge clk_i);
    @(negedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    if (addr == AddrPixelLimit) begin
      limit_cfg = data[LimitW-1:0];
      limits_tried++;
    end
  endtask

  initial begin
    logic [LimitW-1:0] lim;
    logic [31:0]       wdata;
    repeat (5) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // reset limit: frames of 0, 4 (aligned), 1 and 3 pixels, one idle item
    add_item(1'b0, 8'h00, 8'h00, 8'h00, 1'b1);
    add_item(1'b1, 8'h00, 8'h00, 8'h00, 1'b0);
    add_item(1'b1, 8'hFF, 8'hFF, 8'hFF, 1'b0);
    add_item(1'b1, 8'h80, 8'h01, 8'hAA, 1'b0);
    add_item(1'b1, 8'h55, 8'hCC, 8'h0F, 1'b0);
    add_item(1'b0, 8'hFF, 8'hFF, 8'hFF, 1'b1);
    add_item(1'b1, 8'h7F, 8'hFE, 8'h01, 1'b1);
    add_item(1'b0, 8'hFF, 8'hFF, 8'hFF, 1'b0);
    add_item(1'b1, 8'h12, 8'h34, 8'h56, 1'b0);
    add_item(1'b1, 8'hA5, 8'h5A, 8'hC3, 1'b0);
    add_item(1'b1, 8'h01, 8'h80, 8'hFE, 1'b1);
    wait_idle();

    // limit zero: every pixel dropped, frame end still closes
    apb_write(AddrPixelLimit, 32'd0);
    add_item(1'b1, 8'hFF, 8'h00, 8'hFF, 1'b0);
    add_item(1'b1, 8'h00, 8'hFF, 8'h00, 1'b1);
    add_item(1'b0, 8'h00, 8'h00, 8'h00, 1'b1);
    wait_idle();

    // limit two: the third and fourth pixels are dropped
    apb_write(AddrPixelLimit, 32'd2);
    add_item(1'b1, 8'hC0, 8'h03, 8'h18, 1'b0);
    add_item(1'b1, 8'h3C, 8'hE7, 8'h81, 1'b0);
    add_item(1'b1, 8'hFF, 8'hFF, 8'hFF, 1'b0);
    add_item(1'b1, 8'hFF, 8'hFF, 8'hFF, 1'b1);
    wait_idle();

    // unmapped register: limit must stay at two
    apb_write(AddrUnmapped, 32'h0000_0FFF);
    add_item(1'b1, 8'h11, 8'h22, 8'h33, 1'b0);
    add_item(1'b1, 8'h44, 8'h55, 8'h66, 1'b0);
    add_item(1'b1, 8'h77, 8'h88, 8'h99, 1'b0);
    add_item(1'b0, 8'hAA, 8'hBB, 8'hCC, 1'b1);
    wait_idle();

    for (int p = 0; p <= RandPhases; p++) begin
      if (p < RandPhases) begin
        lim   = PhaseLimits[p];
        wdata = {19'h0, lim};
      end else begin
        // small random limit, junk above the register width
        lim   = LimitW'($urandom_range(1, 9));
        wdata = {19'($urandom), lim};
      end
      apb_write(AddrPixelLimit, wdata);
      add_random_frames(ItemsPerPhase);
      wait_idle();
    end

    if (expected_words.size() != 0) error_count++;
    $display("Run: %0d items, %0d pixels encoded, %0d dropped, %0d frames closed.",
             items_sent, pixels_encoded, pixels_dropped, frames_closed);
    $display("Run: %0d words checked over %0d pixel limit settings, %0d mismatches.",
             words_checked, limits_tried, error_count);
    if (error_count == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
design/lpw_pkg.sv
design/lpw_pix_if.sv
design/lpw_word_if.sv
design/lpw_front.sv
design/lpw_cmd_fifo.sv
design/lpw_back.sv
design/led_pixel_wire_word_packer_top.sv
tb/tb_led_pixel_wire_word_packer_top.sv
